/* design/deprng_pkg.sv */
// ----------------------------------------------------------------------------
// deprng_pkg
// Shared types and constants for the dual echo pulse ranger.
// ----------------------------------------------------------------------------
package deprng_pkg;

  localparam int TIME_BITS_DEF = 18;
  localparam int NOW_W         = 17;
  localparam int DIST_W        = 10;
  localparam int CFG_IDX_W     = 1;

  localparam logic [DIST_W-1:0] MAX_DIST_RST = 10'd400;
  localparam logic [NOW_W-1:0]  WRAP_RST     = 17'd100000;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_WRAP  = 1'b1;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  // distance = floor(343 * h / 10000), h = time / 2
  // h at or above HALF_LIMIT always exceeds any clamp limit
  localparam int H_W         = 15;
  localparam int X_W         = 24;
  localparam int P_W         = 48;
  localparam int SOUND_NUM   = 343;
  localparam int HALF_LIMIT  = 29855;
  localparam int RECIP_SHIFT = 37;
  localparam logic [X_W-1:0] RECIP_M = 24'd13743896;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_ARMED    = 2'd1,
    PH_WAIT_LOW = 2'd2
  } phase_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic out;
  } pipe_ctl_t;

endpackage

/* design/deprng_channel.sv */
// ----------------------------------------------------------------------------
// deprng_channel
// Echo phase tracker for one sensor: captures the rising timestamp and
// stores the pulse width on the falling sample.
// ----------------------------------------------------------------------------
module deprng_channel #(
  parameter int TIME_BITS = deprng_pkg::TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sample,
  input  logic                         request,
  input  logic                         high,
  input  logic [deprng_pkg::NOW_W-1:0] now_us,
  input  logic [deprng_pkg::NOW_W-1:0] wrap,
  output logic [TIME_BITS-1:0]         tm
);

  localparam int EW = (TIME_BITS > deprng_pkg::NOW_W + 1) ? TIME_BITS
                                                          : deprng_pkg::NOW_W + 1;

  deprng_pkg::phase_t phase, phase_next;
  logic [TIME_BITS-1:0] tm_next;
  logic [EW-1:0] now_e, tm_e, end_e, dur_e;

  assign now_e = EW'(now_us);
  assign tm_e  = EW'(tm);
  assign end_e = (now_e < tm_e) ? now_e + EW'(wrap) : now_e;
  assign dur_e = end_e - tm_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= deprng_pkg::PH_IDLE;
      tm    <= '0;
    end else begin
      phase <= phase_next;
      tm    <= tm_next;
    end
  end

  always_comb begin
    phase_next = phase;
    tm_next    = tm;
    if (request) begin
      phase_next = deprng_pkg::PH_ARMED;
      tm_next    = '0;
    end else if (sample) begin
      case (phase)
        deprng_pkg::PH_ARMED: begin
          if (high) begin
            tm_next    = TIME_BITS'(now_us);
            phase_next = deprng_pkg::PH_WAIT_LOW;
          end
        end
        deprng_pkg::PH_WAIT_LOW: begin
          if (!high) begin
            tm_next    = TIME_BITS'(dur_e);
            phase_next = deprng_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

endmodule

/* design/deprng_scale.sv */
// ----------------------------------------------------------------------------
// deprng_scale
// Time to centimetre conversion: halve, scale by 343, divide by 10000 via
// reciprocal multiply, clamp. Three stages plus the output register.
// ----------------------------------------------------------------------------
module deprng_scale #(
  parameter int TIME_BITS = deprng_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  deprng_pkg::pipe_ctl_t         ctl,
  input  logic [TIME_BITS-1:0]          tm,
  input  logic [deprng_pkg::DIST_W-1:0] max_dist,
  output logic [deprng_pkg::DIST_W-1:0] distance
);

  localparam int H_W = deprng_pkg::H_W;
  localparam int X_W = deprng_pkg::X_W;
  localparam int P_W = deprng_pkg::P_W;
  localparam int SH  = deprng_pkg::RECIP_SHIFT;

  logic [TIME_BITS-2:0] half;
  logic [H_W-1:0] h1;
  logic [X_W-1:0] x2;
  logic [P_W-1:0] p3;
  logic big1, big2, big3;
  logic [deprng_pkg::DIST_W:0] quo;
  logic [deprng_pkg::DIST_W-1:0] dist_next;

  assign half = tm[TIME_BITS-1:1];

  always_ff @(posedge clk) begin
    if (ctl.s1) begin
      h1   <= H_W'(half);
      big1 <= (32'(half) >= 32'(deprng_pkg::HALF_LIMIT));
    end
    if (ctl.s2) begin
      x2   <= X_W'(X_W'(h1) * X_W'(deprng_pkg::SOUND_NUM));
      big2 <= big1;
    end
    if (ctl.s3) begin
      p3   <= P_W'(x2) * P_W'(deprng_pkg::RECIP_M);
      big3 <= big2;
    end
    if (ctl.out) begin
      distance <= dist_next;
    end
  end

  assign quo = p3[SH+deprng_pkg::DIST_W:SH];

  always_comb begin
    if (big3 || (quo > (deprng_pkg::DIST_W+1)'(max_dist))) begin
      dist_next = max_dist;
    end else begin
      dist_next = quo[deprng_pkg::DIST_W-1:0];
    end
  end

endmodule

/* design/dual_echo_pulse_ranger.sv */
// ----------------------------------------------------------------------------
// dual_echo_pulse_ranger
// Two-channel ultrasonic echo timer with distance readout.
//
//   channel   signals                                     handshake
//   in        action, echo_a, echo_b, now_us              in_valid / in_stall
//   out       distance_a, distance_b                      out_valid / out_stall
//   cfg       cfg_index, cfg_data                         cfg_valid / cfg_ready
//
// One item per cycle while in_stall is low. A request's distances pass through
// three conversion stages and then the output register before they appear.
// Pin samples update the channel state in the cycle they are taken.
// rst is synchronous; it restores the register defaults and idles both
// channels. in_stall rises only when the conversion pipe is full behind a
// stalled output.
// ----------------------------------------------------------------------------
module dual_echo_pulse_ranger #(
  parameter int TIME_BITS = deprng_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             action,
  input  logic                             echo_a,
  input  logic                             echo_b,
  input  logic [deprng_pkg::NOW_W-1:0]     now_us,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [deprng_pkg::DIST_W-1:0]    distance_a,
  output logic [deprng_pkg::DIST_W-1:0]    distance_b,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [deprng_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [deprng_pkg::NOW_W-1:0]     cfg_data
);

  logic [deprng_pkg::DIST_W-1:0] max_dist;
  logic [deprng_pkg::NOW_W-1:0]  wrap;
  logic v1, v2, v3;
  logic accept, sample, request;
  deprng_pkg::pipe_ctl_t ctl;
  logic [TIME_BITS-1:0] tm_a, tm_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_dist <= deprng_pkg::MAX_DIST_RST;
      wrap     <= deprng_pkg::WRAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        deprng_pkg::CFG_MAX_DIST:   max_dist <= cfg_data[deprng_pkg::DIST_W-1:0];
        deprng_pkg::CFG_TIMER_WRAP: wrap     <= cfg_data;
        default: begin
          wrap <= wrap;
        end
      endcase
    end
  end

  // stage loads: a stage takes new contents when it is empty or drains
  assign ctl.out = !out_valid || !out_stall;
  assign ctl.s3  = !v3 || ctl.out;
  assign ctl.s2  = !v2 || ctl.s3;
  assign ctl.s1  = !v1 || ctl.s2;

  assign in_stall = !ctl.s1;
  assign accept   = in_valid && ctl.s1;
  assign sample   = accept && (action == deprng_pkg::ACT_SAMPLE);
  assign request  = accept && (action == deprng_pkg::ACT_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.s1)  v1        <= request;
      if (ctl.s2)  v2        <= v1;
      if (ctl.s3)  v3        <= v2;
      if (ctl.out) out_valid <= v3;
    end
  end

  deprng_channel #(.TIME_BITS(TIME_BITS)) u_chan_a (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample),
    .request (request),
    .high    (echo_a),
    .now_us  (now_us),
    .wrap    (wrap),
    .tm      (tm_a)
  );

  deprng_channel #(.TIME_BITS(TIME_BITS)) u_chan_b (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample),
    .request (request),
    .high    (echo_b),
    .now_us  (now_us),
    .wrap    (wrap),
    .tm      (tm_b)
  );

  deprng_scale #(.TIME_BITS(TIME_BITS)) u_scale_a (
    .clk      (clk),
    .ctl      (ctl),
    .tm       (tm_a),
    .max_dist (max_dist),
    .distance (distance_a)
  );

  deprng_scale #(.TIME_BITS(TIME_BITS)) u_scale_b (
    .clk      (clk),
    .ctl      (ctl),
    .tm       (tm_b),
    .max_dist (max_dist),
    .distance (distance_b)
  );

endmodule

/* design/deprng_checker.sv */
// ----------------------------------------------------------------------------
// deprng_checker
// Port-level checks for the dual echo pulse ranger, bound to the top level.
// ----------------------------------------------------------------------------
module deprng_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [deprng_pkg::DIST_W-1:0]    distance_a,
  input logic [deprng_pkg::DIST_W-1:0]    distance_b,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [deprng_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [deprng_pkg::NOW_W-1:0]     cfg_data
);

  logic [deprng_pkg::DIST_W-1:0] max_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_seen <= deprng_pkg::MAX_DIST_RST;
    end else if (cfg_valid && cfg_ready && (cfg_index == deprng_pkg::CFG_MAX_DIST)) begin
      max_seen <= cfg_data[deprng_pkg::DIST_W-1:0];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(distance_a) && $stable(distance_b))
    else $error("result changed while stalled");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (distance_a <= max_seen) && (distance_b <= max_seen))
    else $error("distance above clamp limit");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result right after reset");

endmodule

bind dual_echo_pulse_ranger deprng_checker u_deprng_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .distance_a (distance_a),
  .distance_b (distance_b),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .cfg_index  (cfg_index),
  .cfg_data   (cfg_data)
);

/* tb/sv/tb_dual_echo_pulse_ranger.sv */
// ----------------------------------------------------------------------------
// tb_dual_echo_pulse_ranger
// Self-checking bench for the two-channel echo ranger. A scoreboard class
// keeps its own copy of both channel trackers and the registers. It turns each
// accepted read request into an expected distance pair and compares every
// output word with it in order. The stimulus is a short directed set
// (reset readout, wrap correction, stamps above the wrap, zero wrap, clamps),
// then random measure/read episodes under several register settings. Random
// gaps on the input side and random stall on the output side are applied.
// ----------------------------------------------------------------------------
module tb_dual_echo_pulse_ranger;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBITS = deprng_pkg::TIME_BITS_DEF;
  localparam int DIST_W = deprng_pkg::DIST_W;
  localparam int NOW_W = deprng_pkg::NOW_W;
  localparam int CFG_IDX_W = deprng_pkg::CFG_IDX_W;
  localparam int CM_DIV = 10000;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [DIST_W-1:0] a;
    logic [DIST_W-1:0] b;
  } dist_pair_t;

  class ranger_scoreboard;
    logic [DIST_W-1:0]    max_cm;
    logic [NOW_W-1:0]     wrap_us;
    deprng_pkg::phase_t   ph_a, ph_b;
    logic [TBITS-1:0]     t_a, t_b;
    dist_pair_t           expected_q[$];
    int                   errors;

    function new();
      errors = 0;
      reset_state();
    endfunction

    function void reset_state();
      max_cm  = deprng_pkg::MAX_DIST_RST;
      wrap_us = deprng_pkg::WRAP_RST;
      ph_a    = deprng_pkg::PH_IDLE;
      ph_b    = deprng_pkg::PH_IDLE;
      t_a     = '0;
      t_b     = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [NOW_W-1:0] data);
      if (idx == deprng_pkg::CFG_MAX_DIST) begin
        max_cm = data[DIST_W-1:0];
      end else if (idx == deprng_pkg::CFG_TIMER_WRAP) begin
        wrap_us = data;
      end
    endfunction

    function void track(inout deprng_pkg::phase_t ph, inout logic [TBITS-1:0] t,
                        input logic high, input logic [NOW_W-1:0] now);
      logic [31:0] fin;
      if (ph == deprng_pkg::PH_ARMED) begin
        if (high) begin
          t  = TBITS'(now);
          ph = deprng_pkg::PH_WAIT_LOW;
        end
      end else if (ph == deprng_pkg::PH_WAIT_LOW) begin
        if (!high) begin
          fin = 32'(now);
          if (fin < 32'(t)) fin = fin + 32'(wrap_us);
          t  = TBITS'(fin - 32'(t));
          ph = deprng_pkg::PH_IDLE;
        end
      end
    endfunction

    function logic [DIST_W-1:0] range_cm(logic [TBITS-1:0] t);
      logic [31:0] d;
      d = (32'(deprng_pkg::SOUND_NUM) * 32'(t >> 1)) / 32'(CM_DIV);
      if (d > 32'(max_cm)) d = 32'(max_cm);
      return d[DIST_W-1:0];
    endfunction

    function void note_input(logic act, logic ea, logic eb, logic [NOW_W-1:0] now);
      dist_pair_t p;
      if (act == deprng_pkg::ACT_SAMPLE) begin
        track(ph_a, t_a, ea, now);
        track(ph_b, t_b, eb, now);
      end else begin
        p.a = range_cm(t_a);
        p.b = range_cm(t_b);
        expected_q.push_back(p);
        t_a  = '0;
        t_b  = '0;
        ph_a = deprng_pkg::PH_ARMED;
        ph_b = deprng_pkg::PH_ARMED;
      end
    endfunction

    function void check_result(logic [DIST_W-1:0] da, logic [DIST_W-1:0] db);
      dist_pair_t p;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word, got distance_a %0d distance_b %0d", $time, da, db);
        errors++;
        return;
      end
      p = expected_q.pop_front();
      if (da !== p.a) begin
        $display("%0t: distance_a expected %0d got %0d", $time, p.a, da);
        errors++;
      end
      if (db !== p.b) begin
        $display("%0t: distance_b expected %0d got %0d", $time, p.b, db);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic                 action;
  logic                 echo_a;
  logic                 echo_b;
  logic [NOW_W-1:0]     now_us;
  logic                 out_valid;
  logic                 out_stall;
  logic [DIST_W-1:0]    distance_a;
  logic [DIST_W-1:0]    distance_b;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [NOW_W-1:0]     cfg_data;

  ranger_scoreboard sb = new();

  int          items_sent = 0;
  int          cycles = 0;
  bit          calm_in = 0;
  bit          calm_out = 0;
  int unsigned clock_us = 0;

  dual_echo_pulse_ranger i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .echo_a     (echo_a),
    .echo_b     (echo_b),
    .now_us     (now_us),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .distance_a (distance_a),
    .distance_b (distance_b),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_word(logic act, logic ea, logic eb, logic [NOW_W-1:0] now);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    echo_a   <= ea;
    echo_b   <= eb;
    now_us   <= now;
    do @(posedge clk); while (in_stall);
    sb.note_input(act, ea, eb, now);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_regs(logic [DIST_W-1:0] max_cm, logic [NOW_W-1:0] wrap);
    cfg_valid <= 1'b1;
    cfg_index <= deprng_pkg::CFG_MAX_DIST;
    cfg_data  <= NOW_W'(max_cm);
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(deprng_pkg::CFG_MAX_DIST, NOW_W'(max_cm));
    cfg_index <= deprng_pkg::CFG_TIMER_WRAP;
    cfg_data  <= wrap;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(deprng_pkg::CFG_TIMER_WRAP, wrap);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [NOW_W-1:0] next_stamp(int unsigned span);
    if ($urandom_range(0, 11) == 0) return NOW_W'($urandom);
    clock_us = clock_us + $urandom_range(0, span);
    if (sb.wrap_us != 0) clock_us = clock_us % sb.wrap_us;
    else clock_us = clock_us & 32'h1FFFF;
    return NOW_W'(clock_us);
  endfunction

  // samples that form one pulse per channel, then a read
  task automatic measure_episode();
    int          n, k;
    int          rise_a, fall_a, rise_b, fall_b;
    int unsigned span;
    logic        ea, eb;
    n = $urandom_range(1, 12);
    case ($urandom_range(0, 3))
      0: begin
        span = 20;
      end
      1: begin
        span = 800;
      end
      2: begin
        span = 6000;
      end
      default: begin
        span = 40000;
      end
    endcase
    rise_a = $urandom_range(0, n);
    fall_a = $urandom_range(rise_a + 1, n + 1);
    rise_b = $urandom_range(0, n);
    fall_b = $urandom_range(rise_b + 1, n + 1);
    for (k = 0; k < n; k++) begin
      ea = (k >= rise_a) && (k < fall_a);
      eb = (k >= rise_b) && (k < fall_b);
      if ($urandom_range(0, 24) == 0) ea = ~ea;
      if ($urandom_range(0, 24) == 0) eb = ~eb;
      send_word(deprng_pkg::ACT_SAMPLE, ea, eb, next_stamp(span));
    end
    send_word(deprng_pkg::ACT_READ, 1'($urandom), 1'($urandom), NOW_W'($urandom));
  endtask

  task automatic noise_burst();
    int k, n;
    n = $urandom_range(1, 6);
    for (k = 0; k < n; k++) begin
      send_word(($urandom_range(0, 3) == 0) ? deprng_pkg::ACT_READ : deprng_pkg::ACT_SAMPLE,
                1'($urandom), 1'($urandom), NOW_W'($urandom));
    end
  endtask

  task automatic random_phase(logic [DIST_W-1:0] max_cm, logic [NOW_W-1:0] wrap, int count);
    int target;
    program_regs(max_cm, wrap);
    calm_in  = ($urandom_range(0, 3) == 0);
    calm_out = ($urandom_range(0, 3) == 0);
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(0, 6) == 0) noise_burst();
      else measure_episode();
    end
    drain();
  endtask

  initial begin : result_sink
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      hold = calm_out ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      sb.check_result(distance_a, distance_b);
    end
  end

  initial begin : stimulus
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    action    <= deprng_pkg::ACT_SAMPLE;
    echo_a    <= 1'b0;
    echo_b    <= 1'b0;
    now_us    <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= deprng_pkg::CFG_MAX_DIST;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // read before any pulse, ignored fields all ones
    send_word(deprng_pkg::ACT_READ, 1'b1, 1'b1, 17'h1FFFF);
    send_word(deprng_pkg::ACT_SAMPLE, 1'b0, 1'b0, 17'd0);
    send_word(deprng_pkg::ACT_SAMPLE, 1'b1, 1'b1, 17'd100);
    send_word(deprng_pkg::ACT_SAMPLE, 1'b1, 1'b0, 17'd500);
    send_word(deprng_pkg::ACT_SAMPLE, 1'b0, 1'b1, 17'd50);
    send_word(deprng_pkg::ACT_READ, 1'b0, 1'b0, 17'd0);
    // stamps above the wrap, backward step masked to the time width
    send_word(deprng_pkg::ACT_SAMPLE, 1'b1, 1'b1, 17'h1FFFF);
    send_word(deprng_pkg::ACT_SAMPLE, 1'b0, 1'b0, 17'd0);
    send_word(deprng_pkg::ACT_READ, 1'b1, 1'b0, 17'd12345);
    send_word(deprng_pkg::ACT_SAMPLE, 1'b1, 1'b1, 17'd0);
    send_word(deprng_pkg::ACT_SAMPLE, 1'b0, 1'b0, 17'd1);
    send_word(deprng_pkg::ACT_READ, 1'b0, 1'b1, 17'd0);
    send_word(deprng_pkg::ACT_SAMPLE, 1'b1, 1'b1, 17'd1000);
    send_word(deprng_pkg::ACT_SAMPLE, 1'b0, 1'b0, 17'd1000);
    send_word(deprng_pkg::ACT_READ, 1'b0, 1'b0, 17'd0);
    drain();

    // zero wrap, top clamp
    program_regs(10'd1023, 17'd0);
    send_word(deprng_pkg::ACT_SAMPLE, 1'b1, 1'b1, 17'd70000);
    send_word(deprng_pkg::ACT_SAMPLE, 1'b0, 1'b1, 17'd10);
    send_word(deprng_pkg::ACT_SAMPLE, 1'b0, 1'b0, 17'd130000);
    send_word(deprng_pkg::ACT_READ, 1'b1, 1'b1, 17'h1FFFF);
    drain();

    // clamp to zero, smallest nonzero wrap
    program_regs(10'd0, 17'd1);
    send_word(deprng_pkg::ACT_SAMPLE, 1'b1, 1'b1, 17'd5);
    send_word(deprng_pkg::ACT_SAMPLE, 1'b0, 1'b0, 17'd7);
    send_word(deprng_pkg::ACT_READ, 1'b0, 1'b0, 17'd0);
    drain();

    random_phase(DIST_W'($urandom), 17'h1FFFF, 105);
    random_phase(10'd1023, 17'h1FFFF, 105);
    random_phase(deprng_pkg::MAX_DIST_RST, deprng_pkg::WRAP_RST, 105);
    random_phase(DIST_W'($urandom), NOW_W'($urandom_range(1, 131071)), 105);
    random_phase(10'd1023, NOW_W'($urandom_range(1, 1000)), 105);
    random_phase(DIST_W'($urandom), deprng_pkg::WRAP_RST, 105);

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
